// ----- hw/rtl/tql_pkg.sv -----
`timescale 1ns / 1ps

package tql_pkg;

    localparam int POSITIONS   = 128;
    localparam int ACTIONS     = 2;
    localparam int Q_BITS      = 16;
    localparam int VEL_CLASSES = 3;
    localparam int STATE_COUNT = POSITIONS * VEL_CLASSES;
    localparam int IDX_W       = $clog2(STATE_COUNT);
    localparam int ACT_W       = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
    localparam int REWARD_W    = 16;
    localparam int SUM_W       = ((Q_BITS > REWARD_W) ? Q_BITS : REWARD_W) + 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_SHIFT     = 2'd2;

    typedef logic [ACTIONS-1:0][Q_BITS-1:0] t_row;

    typedef struct packed {
        logic              episode_start;
        logic              episode_done;
        logic signed [15:0] reward;
        logic [6:0]        position;
        logic              on_floor;
        logic              rising;
        logic              explore;
        logic [2:0]        random_bits;
    } t_in_item;

    typedef struct packed {
        logic action;
        logic action_valid;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_OLD,
        S_UPD,
        S_PICK
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd_last;
        logic cap_new;
        logic upd;
        logic pick;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

endpackage

// ----- hw/rtl/tql_ctrl.sv -----
`timescale 1ns / 1ps

module tql_ctrl
    import tql_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD: n_state = S_UPD;
            S_UPD:    n_state = S_PICK;
            S_PICK:   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_RD_OLD: begin
                o_cmd.rd_last = 1'b1;
                o_cmd.cap_new = 1'b1;
            end
            S_UPD:   o_cmd.upd  = 1'b1;
            S_PICK:  o_cmd.pick = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/tql_dp.sv -----
`timescale 1ns / 1ps

module tql_dp
    import tql_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  t_in_item              i_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result               o_result,
    output logic                  o_res_strobe
);

    // Q store: one row per state, all actions side by side
    t_row              mem [STATE_COUNT];
    t_row              r_rd;

    logic              r_learn;
    logic [3:0]        r_alpha;
    logic [3:0]        r_gamma;

    t_in_item          r_item;
    logic [IDX_W-1:0]  r_idx;
    t_row              r_new_row;
    logic signed [Q_BITS-1:0] r_best;

    logic [IDX_W-1:0]  r_last_index;
    logic [ACT_W-1:0]  r_last_action;
    logic              r_have_last;
    logic [IDX_W-1:0]  r_clr_cnt;

    t_result           r_result;
    logic              r_strobe;

    logic [IDX_W-1:0]  idx_in;
    logic [IDX_W-1:0]  pos_sat;
    logic [IDX_W-1:0]  vel;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    t_row              wdata;
    logic              we;
    logic              upd_en;

    logic signed [Q_BITS-1:0] rd_max;
    logic signed [Q_BITS-1:0] fut;
    logic signed [Q_BITS-1:0] q_old;
    logic signed [SUM_W-1:0]  diff;
    logic signed [SUM_W-1:0]  q_sum;
    logic signed [Q_BITS-1:0] q_new;
    t_row                     upd_row;

    logic [ACT_W-1:0]  greedy;
    logic [ACT_W-1:0]  action;

    localparam logic signed [SUM_W-1:0] Q_HI = SUM_W'((64'sd1 <<< (Q_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] Q_LO = -Q_HI - SUM_W'(1);

    // state index of the incoming observation
    always_comb begin
        if (32'(i_item.position) > POSITIONS - 1) begin
            pos_sat = IDX_W'(POSITIONS - 1);
        end else begin
            pos_sat = IDX_W'(i_item.position);
        end
        if (i_item.on_floor) begin
            vel = '0;
        end else if (i_item.rising) begin
            vel = IDX_W'(1);
        end else begin
            vel = IDX_W'(2);
        end
        idx_in = IDX_W'(pos_sat * IDX_W'(VEL_CLASSES)) + vel;
    end

    // first maximum of the row just read
    always_comb begin
        rd_max = $signed(r_rd[0]);
        for (int a = 1; a < ACTIONS; a++) begin
            if ($signed(r_rd[a]) > rd_max) begin
                rd_max = $signed(r_rd[a]);
            end
        end
    end

    // update of the previous transition, old row is in r_rd
    always_comb begin
        upd_en = r_learn && r_have_last && !r_item.episode_start;
        fut    = r_item.episode_done ? '0 : r_best;
        q_old  = $signed(r_rd[r_last_action]);
        diff   = SUM_W'($signed(r_item.reward)) + SUM_W'(fut) - SUM_W'(fut >>> r_gamma)
                 - SUM_W'(q_old);
        q_sum  = (diff >>> r_alpha) + SUM_W'(q_old);
        if (q_sum > Q_HI) begin
            q_new = Q_HI[Q_BITS-1:0];
        end else if (q_sum < Q_LO) begin
            q_new = Q_LO[Q_BITS-1:0];
        end else begin
            q_new = q_sum[Q_BITS-1:0];
        end
        upd_row                = r_rd;
        upd_row[r_last_action] = q_new;
    end

    always_comb begin
        greedy = '0;
        for (int a = 1; a < ACTIONS; a++) begin
            if ($signed(r_new_row[a]) > $signed(r_new_row[greedy])) begin
                greedy = ACT_W'(a);
            end
        end
        if (r_learn && r_item.explore) begin
            action = (r_item.random_bits != '0) ? '0 : ACT_W'(1);
        end else begin
            action = greedy;
        end
    end

    assign raddr = i_cmd.rd_last ? r_last_index : idx_in;
    assign we    = i_cmd.clr_wr || (i_cmd.upd && upd_en);
    assign waddr = i_cmd.clr_wr ? r_clr_cnt : r_last_index;
    assign wdata = i_cmd.clr_wr ? '0 : upd_row;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn <= 1'b1;
            r_alpha <= 4'd6;
            r_gamma <= 4'd6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEARNING_ENABLE: r_learn <= i_cfg_data[0];
                CFG_ALPHA_SHIFT:     r_alpha <= i_cfg_data;
                CFG_GAMMA_SHIFT:     r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
            r_idx  <= idx_in;
        end
        if (i_cmd.cap_new) begin
            r_new_row <= r_rd;
            r_best    <= rd_max;
        end else if (i_cmd.upd && upd_en && r_last_index == r_idx) begin
            r_new_row[r_last_action] <= q_new;
        end
        if (i_cmd.pick) begin
            r_result.action       <= r_item.episode_done ? 1'b0 : action[0];
            r_result.action_valid <= !r_item.episode_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index  <= '0;
            r_last_action <= '0;
            r_have_last   <= 1'b0;
            r_clr_cnt     <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= i_cmd.pick;
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (i_cmd.pick) begin
                if (r_item.episode_done) begin
                    r_have_last <= 1'b0;
                end else begin
                    r_last_index  <= r_idx;
                    r_last_action <= action;
                    r_have_last   <= 1'b1;
                end
            end
        end
    end

    assign o_status.clr_last = (r_clr_cnt == IDX_W'(STATE_COUNT - 1));
    assign o_result          = r_result;
    assign o_res_strobe      = r_strobe;

endmodule

// ----- hw/rtl/tabular_q_learning_agent.sv -----
`timescale 1ns / 1ps
// channel   handshake                       payload
// --------  ------------------------------  ---------------------------
// step in   start && !busy                  i_item (t_in_item)
// result    o_res_strobe, one cycle         o_result (t_result)
// config    i_cfg_valid && o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each step runs in this order, start to start: read of the new state's row, read
// of the previous state's row on the same single read port, update, pick.
// The result strobes in the cycle after the pick; busy is low then.
// After reset the Q store is zeroed one row per cycle, all STATE_COUNT (384)
// rows; busy stays high until the clear is done. Config is always ready.
// Results cannot be stalled; there is no output backpressure.

module tabular_q_learning_agent
    import tql_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output t_result               o_result,
    output logic                  o_res_strobe,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tql_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    tql_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_item       (i_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_result     (o_result),
        .o_res_strobe (o_res_strobe)
    );

endmodule
